>>> rtl/core/smwq_pkg.sv
`timescale 1ns / 1ps
package smwq_pkg;

	localparam int ID_W    = 16;
	localparam int COUNT_W = 7;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_TAKE = 1'b1;

	typedef struct packed {
		logic            command;
		logic [ID_W-1:0] state_id;
		logic [ID_W-1:0] visit_id;
		logic [ID_W-1:0] avoid_id;
	} smwq_item_t;

	typedef struct packed {
		logic               found;
		logic [ID_W-1:0]    taken_state;
		logic [ID_W-1:0]    taken_visit;
		logic               overflow;
		logic [COUNT_W-1:0] entry_count;
	} smwq_result_t;

	typedef struct packed {
		logic [ID_W-1:0] state_id;
		logic [ID_W-1:0] visit_id;
	} smwq_entry_t;

	typedef struct packed {
		logic            push;
		logic            take_start;
		logic            shift;
		logic [ID_W-1:0] avoid_id;
		smwq_entry_t     push_entry;
	} smwq_cell_ctl_t;

	typedef struct packed {
		logic hit;
		logic stop;
	} smwq_cell_stat_t;

	typedef enum logic {
		SMWQ_IDLE,
		SMWQ_SCAN
	} smwq_state_t;

endpackage

>>> rtl/core/smwq_cell.sv
`timescale 1ns / 1ps
module smwq_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  smwq_pkg::smwq_cell_ctl_t ctl,
	input  logic                     prev_valid,
	input  logic                     next_valid,
	input  smwq_pkg::smwq_entry_t    next_entry,
	input  logic                     token_in,
	output logic                     valid,
	output smwq_pkg::smwq_entry_t    entry,
	output logic                     token_out,
	output smwq_pkg::smwq_cell_stat_t stat
);
	import smwq_pkg::*;

	logic        valid_q;
	logic        tok_q;
	logic        ahead_q;
	smwq_entry_t entry_q;
	logic        match;

	assign match     = (entry_q.state_id == ctl.avoid_id);
	assign token_out = tok_q & valid_q & match;
	assign stat.hit  = tok_q & valid_q & ~match;
	assign stat.stop = tok_q & ~valid_q;
	assign valid     = valid_q;
	assign entry     = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= 1'b0;
			ahead_q <= 1'b0;
		end else begin
			tok_q <= token_in;
			if (ctl.take_start) begin
				ahead_q <= 1'b1;
			end else if (tok_q) begin
				ahead_q <= 1'b0;
			end
			if (ctl.push && !valid_q && prev_valid) begin
				valid_q <= 1'b1;
			end else if (ctl.shift && ahead_q) begin
				valid_q <= next_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push && !valid_q && prev_valid) begin
			entry_q <= ctl.push_entry;
		end else if (ctl.shift && ahead_q) begin
			entry_q <= next_entry;
		end
	end

endmodule

>>> rtl/core/skip_match_work_queue.sv
`timescale 1ns / 1ps
// Ordered queue of (state, visit) pairs held in a row of cells, oldest in cell 0.
// A push is applied at the accepting edge and its result strobes on done in the
// next cycle; busy stays low, so a command may follow every cycle. A take sends
// a search token down the cells one cell per cycle and holds busy until the token
// reaches the first entry whose state differs from the avoid id, or the first
// empty cell or the end of the row when none qualifies. Its result strobes on
// done as busy falls. Removal closes the gap: every cell from the removed one
// on takes its successor's entry together. Results cannot be stalled: each is
// on result for exactly one cycle while done is high.
module skip_match_work_queue #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  smwq_pkg::smwq_item_t   item,
	output logic                   busy,
	output logic                   done,
	output smwq_pkg::smwq_result_t result
);
	import smwq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	smwq_state_t     state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	smwq_result_t    res_q, res_d;
	logic            done_q, done_d;
	logic [ID_W-1:0] avoid_q;
	smwq_cell_ctl_t  ctl;

	logic [QUEUE_DEPTH-1:0] cell_valid;
	logic [QUEUE_DEPTH-1:0] cell_tok;
	logic [QUEUE_DEPTH-1:0] cell_hit;
	logic [QUEUE_DEPTH-1:0] cell_stop;
	smwq_entry_t            cell_entry [QUEUE_DEPTH];
	smwq_entry_t            hit_entry;

	logic accept, full, hit_any, end_any;

	assign accept  = start && (state_q == SMWQ_IDLE);
	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign hit_any = |cell_hit;
	assign end_any = (|cell_stop) | cell_tok[QUEUE_DEPTH-1];

	always_comb begin
		ctl.push                = accept && (item.command == CMD_PUSH);
		ctl.take_start          = accept && (item.command == CMD_TAKE);
		ctl.shift               = (state_q == SMWQ_SCAN) && hit_any;
		ctl.avoid_id            = avoid_q;
		ctl.push_entry.state_id = item.state_id;
		ctl.push_entry.visit_id = item.visit_id;
	end

	always_ff @(posedge clk) begin
		if (ctl.take_start) begin
			avoid_q <= item.avoid_id;
		end
	end

	genvar g;
	generate
		for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
			smwq_cell_stat_t st;
			smwq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.prev_valid ((g == 0) ? 1'b1 : cell_valid[(g == 0) ? 0 : g - 1]),
				.next_valid ((g == QUEUE_DEPTH - 1) ? 1'b0 :
					cell_valid[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
				.next_entry (cell_entry[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
				.token_in   ((g == 0) ? ctl.take_start : cell_tok[(g == 0) ? 0 : g - 1]),
				.valid      (cell_valid[g]),
				.entry      (cell_entry[g]),
				.token_out  (cell_tok[g]),
				.stat       (st)
			);
			assign cell_hit[g]  = st.hit;
			assign cell_stop[g] = st.stop;
		end
	endgenerate

	always_comb begin
		hit_entry = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			hit_entry = hit_entry | (cell_hit[i] ? cell_entry[i] : '0);
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		res_d   = res_q;
		done_d  = 1'b0;
		case (state_q)
			SMWQ_IDLE: begin
				if (ctl.push) begin
					if (!full) begin
						count_d = count_q + CNT_W'(1);
					end
					res_d.found       = 1'b0;
					res_d.taken_state = '0;
					res_d.taken_visit = '0;
					res_d.overflow    = full;
					res_d.entry_count = COUNT_W'(count_d);
					done_d            = 1'b1;
				end else if (ctl.take_start) begin
					state_d = SMWQ_SCAN;
				end
			end
			SMWQ_SCAN: begin
				if (hit_any) begin
					count_d           = count_q - CNT_W'(1);
					res_d.found       = 1'b1;
					res_d.taken_state = hit_entry.state_id;
					res_d.taken_visit = hit_entry.visit_id;
					res_d.overflow    = 1'b0;
					res_d.entry_count = COUNT_W'(count_d);
					done_d            = 1'b1;
					state_d           = SMWQ_IDLE;
				end else if (end_any) begin
					res_d.found       = 1'b0;
					res_d.taken_state = '0;
					res_d.taken_visit = '0;
					res_d.overflow    = 1'b0;
					res_d.entry_count = COUNT_W'(count_q);
					done_d            = 1'b1;
					state_d           = SMWQ_IDLE;
				end
			end
			default: begin
				state_d = SMWQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SMWQ_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign busy   = (state_q == SMWQ_SCAN);
	assign done   = done_q;
	assign result = res_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while scanning");
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.found && result.overflow))
		else $error("found and overflow together");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("occupancy beyond depth");
	a_token_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_hit | cell_stop))
		else $error("more than one cell holds the search token");
	a_cmd_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted command left no result and no scan");
`endif

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import smwq_pkg::*;

	localparam int DEPTH       = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DIR_COUNT   = 21;
	localparam int PRINT_CAP   = 40;

	typedef struct packed {
		smwq_item_t   stim;
		logic         pinned;
		smwq_result_t want;
	} dir_row_t;

	logic         clk    = 1'b0;
	logic         arst_n = 1'b0;
	logic         start  = 1'b0;
	smwq_item_t   item   = '0;
	logic         busy;
	logic         done;
	smwq_result_t result;

	logic         pinned_now = 1'b0;
	smwq_result_t pinned_res = '0;

	smwq_entry_t  queue_model[$];
	smwq_result_t pending_results[$];
	smwq_result_t oldest;
	dir_row_t     dir_rows [0:DIR_COUNT-1];
	logic [ID_W-1:0] id_pool [0:2];

	int unsigned cycle_count = 0;
	int unsigned error_count = 0;
	int unsigned idle_pct    = 0;
	int unsigned n_pushes    = 0;
	int unsigned n_drops     = 0;
	int unsigned n_hits      = 0;
	int unsigned n_misses    = 0;
	int unsigned peak_count  = 0;

	skip_match_work_queue #(.QUEUE_DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always #2 clk = ~clk;

	function automatic smwq_result_t apply_command(smwq_item_t cmd);
		smwq_result_t res;
		int hit;
		res = '0;
		hit = -1;
		if (cmd.command == CMD_PUSH) begin
			n_pushes++;
			if (queue_model.size() >= DEPTH) begin
				res.overflow = 1'b1;
				n_drops++;
			end else begin
				queue_model.push_back('{cmd.state_id, cmd.visit_id});
			end
		end else begin
			foreach (queue_model[k]) begin
				if (hit < 0 && queue_model[k].state_id != cmd.avoid_id)
					hit = k;
			end
			if (hit >= 0) begin
				res.found       = 1'b1;
				res.taken_state = queue_model[hit].state_id;
				res.taken_visit = queue_model[hit].visit_id;
				queue_model.delete(hit);
				n_hits++;
			end else begin
				n_misses++;
			end
		end
		if (queue_model.size() > peak_count)
			peak_count = queue_model.size();
		res.entry_count = COUNT_W'(queue_model.size());
		return res;
	endfunction

	function automatic smwq_item_t random_command(int unsigned push_pct);
		smwq_item_t cmd;
		int unsigned pick;
		cmd.command  = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_TAKE;
		cmd.state_id = ($urandom_range(9) < 6) ? id_pool[$urandom_range(2)] : ID_W'($urandom);
		cmd.visit_id = ID_W'($urandom);
		pick = $urandom_range(9);
		if (pick < 4 && queue_model.size() != 0)
			cmd.avoid_id = queue_model[0].state_id;
		else if (pick < 6 && queue_model.size() != 0)
			cmd.avoid_id = queue_model[$urandom_range(queue_model.size() - 1)].state_id;
		else if (pick < 8)
			cmd.avoid_id = id_pool[$urandom_range(2)];
		else
			cmd.avoid_id = ID_W'($urandom);
		return cmd;
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= PRINT_CAP)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// idle per profile, return at the falling edge where the next transfer is driven
	task automatic wait_slot();
		int unsigned gap;
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 5);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
	endtask

	task automatic present(smwq_item_t cmd, logic pin, smwq_result_t pin_res);
		start      <= 1'b1;
		item       <= cmd;
		pinned_now <= pin;
		pinned_res <= pin_res;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (done === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: %p", result));
			end else begin
				oldest = pending_results.pop_front();
				if (result.found !== oldest.found)
					report_mismatch($sformatf("found %b, want %b", result.found, oldest.found));
				if (result.taken_state !== oldest.taken_state)
					report_mismatch($sformatf("taken_state %h, want %h",
						result.taken_state, oldest.taken_state));
				if (result.taken_visit !== oldest.taken_visit)
					report_mismatch($sformatf("taken_visit %h, want %h",
						result.taken_visit, oldest.taken_visit));
				if (result.overflow !== oldest.overflow)
					report_mismatch($sformatf("overflow %b, want %b",
						result.overflow, oldest.overflow));
				if (result.entry_count !== oldest.entry_count)
					report_mismatch($sformatf("entry_count %0d, want %0d",
						result.entry_count, oldest.entry_count));
			end
		end
		if (arst_n && start && busy === 1'b0) begin
			oldest = apply_command(item);
			pending_results.push_back(pinned_now ? pinned_res : oldest);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		smwq_result_t none;
		smwq_item_t cmd;
		int unsigned backlog;
		none = '0;
		dir_rows = '{
			'{'{CMD_TAKE, 16'hFFFF, 16'hFFFF, 16'h0000}, 1'b1, '{1'b0, 16'h0000, 16'h0000, 1'b0, 7'd0}},
			'{'{CMD_TAKE, 16'h0000, 16'h0000, 16'hFFFF}, 1'b1, '{1'b0, 16'h0000, 16'h0000, 1'b0, 7'd0}},
			'{'{CMD_PUSH, 16'h0000, 16'hFFFF, 16'hFFFF}, 1'b1, '{1'b0, 16'h0000, 16'h0000, 1'b0, 7'd1}},
			'{'{CMD_PUSH, 16'hFFFF, 16'h0000, 16'h0000}, 1'b1, '{1'b0, 16'h0000, 16'h0000, 1'b0, 7'd2}},
			'{'{CMD_PUSH, 16'hFFFF, 16'h1234, 16'h0000}, 1'b1, '{1'b0, 16'h0000, 16'h0000, 1'b0, 7'd3}},
			'{'{CMD_TAKE, 16'h0000, 16'h0000, 16'hFFFF}, 1'b1, '{1'b1, 16'h0000, 16'hFFFF, 1'b0, 7'd2}},
			'{'{CMD_TAKE, 16'h0000, 16'h0000, 16'hFFFF}, 1'b1, '{1'b0, 16'h0000, 16'h0000, 1'b0, 7'd2}},
			'{'{CMD_PUSH, 16'h0001, 16'hAAAA, 16'hFFFF}, 1'b1, '{1'b0, 16'h0000, 16'h0000, 1'b0, 7'd3}},
			'{'{CMD_TAKE, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{1'b1, 16'h0001, 16'hAAAA, 1'b0, 7'd2}},
			'{'{CMD_TAKE, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{1'b1, 16'hFFFF, 16'h0000, 1'b0, 7'd1}},
			'{'{CMD_TAKE, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{1'b1, 16'hFFFF, 16'h1234, 1'b0, 7'd0}},
			'{'{CMD_PUSH, 16'h5555, 16'h5555, 16'hAAAA}, 1'b0, '0},
			'{'{CMD_PUSH, 16'hAAAA, 16'hAAAA, 16'h5555}, 1'b0, '0},
			'{'{CMD_PUSH, 16'h5555, 16'h0F0F, 16'h0000}, 1'b0, '0},
			'{'{CMD_TAKE, 16'h0000, 16'h0000, 16'h5555}, 1'b0, '0},
			'{'{CMD_TAKE, 16'h0000, 16'h0000, 16'hAAAA}, 1'b0, '0},
			'{'{CMD_TAKE, 16'hFFFF, 16'hFFFF, 16'h5555}, 1'b0, '0},
			'{'{CMD_TAKE, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
			'{'{CMD_PUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
			'{'{CMD_TAKE, 16'h0000, 16'h0000, 16'hFFFF}, 1'b0, '0},
			'{'{CMD_TAKE, 16'h0000, 16'h0000, 16'hFFFE}, 1'b0, '0}
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r]) begin
			wait_slot();
			present(dir_rows[r].stim, dir_rows[r].pinned, dir_rows[r].want);
		end
		drain_results();

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 15 : (phase == 1) ? 46 : 0;
			foreach (id_pool[k])
				id_pool[k] = ID_W'($urandom);
			id_pool[1] = (phase == 0) ? '0 : (phase == 1) ? '1 : id_pool[1];

			// fill past full, then drain
			repeat (75) begin
				wait_slot();
				present(random_command(95), 1'b0, none);
			end
			repeat (35) begin
				wait_slot();
				present(random_command(12), 1'b0, none);
			end
			drain_results();

			// empty the queue, then build a run of one state that most takes must skip
			backlog = queue_model.size();
			repeat (backlog) begin
				wait_slot();
				cmd = random_command(0);
				if (queue_model.size() != 0)
					cmd.avoid_id = ~queue_model[0].state_id;
				present(cmd, 1'b0, none);
			end
			repeat (10) begin
				wait_slot();
				cmd = random_command(100);
				cmd.state_id = id_pool[0];
				present(cmd, 1'b0, none);
			end
			repeat (8) begin
				wait_slot();
				cmd = random_command(0);
				cmd.avoid_id = ($urandom_range(7) < 5) ? id_pool[0] : ID_W'($urandom);
				present(cmd, 1'b0, none);
			end
			drain_results();
		end

		repeat (8) @(posedge clk);
		$display("Ran %0d pushes (%0d dropped on a full queue) and %0d takes (%0d removed, %0d none)",
			n_pushes, n_drops, n_hits + n_misses, n_hits, n_misses);
		$display("Peak occupancy %0d of %0d under three sender idle profiles, %0d cycles",
			peak_count, DEPTH, cycle_count);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
